@@ sv/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg
// Shared opcodes, result status codes and control bundles for the sorted
// list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 3;
  localparam int FIELD_W  = 32;
  localparam int COUNT_W  = 5;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_LIST   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd6;

  typedef struct packed {
    logic exec;   // run a single-result request and load the output
    logic rot;    // emit cell zero and rotate the held entries
    logic last;   // mark the loaded result as final
  } cmd_t;

  typedef struct packed {
    logic empty;  // no entries held
  } sts_t;

endpackage

@@ sv/sle_ctrl.sv @@
// ----------------------------------------------------------------------------
// sle_ctrl
// Request sequencer: accepts requests, steps list dumps one entry per
// transfer and owns the result valid flag.
// ----------------------------------------------------------------------------
module sle_ctrl #(
  parameter int CW = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sle_pkg::OPCODE_W-1:0] opcode,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [CW-1:0]                count,
  input  sle_pkg::sts_t                sts,
  output sle_pkg::cmd_t                cmd
);

  typedef enum logic {IDLE, LIST} state_t;

  state_t        state;
  logic [CW-1:0] idx;
  logic          out_free;
  logic          take;
  logic          start_list;

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == IDLE) && out_free;
  assign take       = s_tvalid && s_tready;
  assign start_list = (opcode == sle_pkg::OP_LIST) && !sts.empty;

  always_comb begin
    cmd.exec = take && !start_list;
    cmd.rot  = (state == LIST) && out_free;
    cmd.last = (state != LIST) || (idx == count - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (take && start_list) begin
            state <= LIST;
            idx   <= '0;
          end
        end
        LIST: begin
          if (cmd.rot) begin
            idx <= idx + CW'(1);
            if (cmd.last) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
      if (cmd.exec || cmd.rot) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/sle_dpath.sv @@
// ----------------------------------------------------------------------------
// sle_dpath
// Row of sorted value cells with per-cell compare, shift-insert, shift-delete
// and rotate paths, plus the registered result payload.
// ----------------------------------------------------------------------------
module sle_dpath #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sle_pkg::OPCODE_W-1:0] opcode,
  input  logic [sle_pkg::FIELD_W-1:0]  operand_value,
  input  sle_pkg::cmd_t                cmd,
  output sle_pkg::sts_t                sts,
  output logic [CW-1:0]                count,
  output logic [sle_pkg::STATUS_W-1:0] status,
  output logic [sle_pkg::FIELD_W-1:0]  element_value,
  output logic [sle_pkg::COUNT_W-1:0]  entry_count,
  output logic                         last_result
);

  localparam int EW = (VALUE_WIDTH > sle_pkg::FIELD_W) ? VALUE_WIDTH : sle_pkg::FIELD_W;
  localparam int XW = (CW > sle_pkg::COUNT_W) ? CW : sle_pkg::COUNT_W;

  logic signed [VALUE_WIDTH-1:0] cells [DEPTH];
  logic signed [VALUE_WIDTH-1:0] cells_next [DEPTH];
  logic signed [EW-1:0]          op_ext;
  logic signed [VALUE_WIDTH-1:0] val;
  logic signed [EW-1:0]          out_ext;
  logic [DEPTH-1:0]              lt;
  logic [DEPTH-1:0]              eq;
  logic                          hit;
  logic                          full;
  logic [CW-1:0]                 count_next;
  logic [sle_pkg::STATUS_W-1:0]  status_next;
  logic [XW-1:0]                 count_ext;

  assign op_ext = EW'($signed(operand_value));
  assign val    = op_ext[VALUE_WIDTH-1:0];
  assign hit    = |eq;
  assign full   = (count == CW'(DEPTH));
  assign sts.empty = (count == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic held;
    assign held  = CW'(i) < count;
    assign lt[i] = held && (cells[i] < val);
    assign eq[i] = held && (cells[i] == val);

    always_comb begin
      cells_next[i] = cells[i];
      if (cmd.rot) begin
        if ((i == DEPTH - 1) || (CW'(i) == count - CW'(1))) begin
          cells_next[i] = cells[0];
        end else begin
          cells_next[i] = cells[(i + 1) % DEPTH];
        end
      end else if (cmd.exec) begin
        if (opcode == sle_pkg::OP_INSERT && !full && !lt[i]) begin
          if (i == 0) begin
            cells_next[i] = val;
          end else if (lt[(i + DEPTH - 1) % DEPTH]) begin
            cells_next[i] = val;
          end else begin
            cells_next[i] = cells[(i + DEPTH - 1) % DEPTH];
          end
        end else if (opcode == sle_pkg::OP_DELETE && hit && !lt[i] && i != DEPTH - 1) begin
          cells_next[i] = cells[(i + 1) % DEPTH];
        end
      end
    end

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) begin
          cells[i] <= '0;
        end else begin
          cells[i] <= cells_next[i];
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  always_comb begin
    count_next  = count;
    status_next = sle_pkg::ST_NOT_FOUND;
    case (opcode)
      sle_pkg::OP_INSERT: begin
        if (full) begin
          status_next = sle_pkg::ST_FULL;
        end else begin
          status_next = sle_pkg::ST_INSERTED;
          count_next  = count + CW'(1);
        end
      end
      sle_pkg::OP_SEARCH: begin
        status_next = hit ? sle_pkg::ST_FOUND : sle_pkg::ST_NOT_FOUND;
      end
      sle_pkg::OP_DELETE: begin
        if (hit) begin
          status_next = sle_pkg::ST_DELETED;
          count_next  = count - CW'(1);
        end
      end
      sle_pkg::OP_LIST: begin
        status_next = sle_pkg::ST_EMPTY;
      end
      default: status_next = sle_pkg::ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  assign out_ext = cmd.rot ? EW'(cells[0]) : EW'(val);

  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.rot) begin
      status        <= cmd.rot ? sle_pkg::ST_LISTED : status_next;
      element_value <= out_ext[sle_pkg::FIELD_W-1:0];
      count_ext     <= XW'(cmd.rot ? count : count_next);
      last_result   <= cmd.last;
    end
  end

  assign entry_count = count_ext[sle_pkg::COUNT_W-1:0];

endmodule

@@ sv/sorted_list_engine.sv @@
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded ascending multiset of signed values with insert, search, delete
// and list requests.
// ----------------------------------------------------------------------------
// Single results: a request shows its result in the cycle after transfer.
// List: the first entry follows the LIST state and the output register, then
// one entry per cycle unless stalled. Throughput: 1 request per cycle for
// single results unless stalled; a list blocks input until its last entry.
// Reset: one entry of value 0 held, output empty, ready in the next cycle.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // operand_value[31:0]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // element_value[31:0], entry_count[36:32], pad
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast
);

  localparam int CW = $clog2(DEPTH + 1);

  sle_pkg::cmd_t                cmd;
  sle_pkg::sts_t                sts;
  logic [CW-1:0]                count;
  logic [sle_pkg::FIELD_W-1:0]  element_value;
  logic [sle_pkg::COUNT_W-1:0]  entry_count;

  sle_ctrl #(.CW(CW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .count    (count),
    .sts      (sts),
    .cmd      (cmd)
  );

  sle_dpath #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH), .CW(CW)) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .opcode        (s_tuser),
    .operand_value (s_tdata),
    .cmd           (cmd),
    .sts           (sts),
    .count         (count),
    .status        (m_tuser),
    .element_value (element_value),
    .entry_count   (entry_count),
    .last_result   (m_tlast)
  );

  assign m_tdata = {3'b000, entry_count, element_value};

endmodule

@@ sv/sle_checker.sv @@
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on result sequencing for the sorted list engine.
// ----------------------------------------------------------------------------
module sle_checker #(
  parameter int DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_multi_listed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == sle_pkg::ST_LISTED)
    else $error("non-final result is not a listed entry");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == sle_pkg::ST_EMPTY |-> m_tlast && m_tdata[36:32] == 5'd0)
    else $error("list-empty result with entries or not final");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == sle_pkg::ST_FULL |-> m_tdata[36:32] == 5'(DEPTH))
    else $error("full reported below capacity");

  a_list_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("input taken during a list dump");

endmodule

bind sorted_list_engine sle_checker #(.DEPTH(DEPTH)) u_sle_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ tb/tb_sorted_list_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_engine
// Self-checking bench for the sorted list engine. A directed table covers the
// reset contents, both value extremes, duplicates, a full list, a delete and a
// search on an empty list and an empty listing. Random traffic then alternates
// between filling and draining the list. Typed rows are checked against the
// table, all other results against a shadow list kept in the bench.
// Source and sink stalls are random in the table and two of three phases.
// ----------------------------------------------------------------------------
module tb_sorted_list_engine;

  localparam int LIST_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 126;
  localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_ROWS     = 26;

  typedef struct packed {
    logic [sle_pkg::STATUS_W-1:0] status;
    logic [sle_pkg::FIELD_W-1:0]  value;
    logic [sle_pkg::COUNT_W-1:0]  count;
    logic                         last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } typed_result_t;

  typedef struct packed {
    logic [sle_pkg::OPCODE_W-1:0] op;
    logic [sle_pkg::FIELD_W-1:0]  operand;
    logic                         typed;
    logic [sle_pkg::STATUS_W-1:0] status;
    logic [sle_pkg::COUNT_W-1:0]  count;
  } stim_row_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // operand_value[31:0]
  logic [1:0]  s_tuser  = '0;   // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // element_value[31:0], entry_count[36:32], pad
  logic [2:0]  m_tuser;         // status[2:0]
  logic        m_tlast;

  typed_result_t row_typed = '0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  logic signed [sle_pkg::FIELD_W-1:0] shadow_list [LIST_DEPTH] = '{default: '0};
  int      shadow_count = 1;
  result_t expected_results [$];

  int error_count     = 0;
  int results_checked = 0;
  int requests_sent   = 0;
  int full_answers    = 0;
  int empty_answers   = 0;
  int cycle_count     = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{sle_pkg::OP_LIST,   32'h0000_0000, 1'b1, sle_pkg::ST_LISTED,    5'd1},
    '{sle_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, sle_pkg::ST_FOUND,     5'd1},
    '{sle_pkg::OP_DELETE, 32'h0000_0000, 1'b1, sle_pkg::ST_DELETED,   5'd0},
    '{sle_pkg::OP_DELETE, 32'h0000_0005, 1'b1, sle_pkg::ST_NOT_FOUND, 5'd0},
    '{sle_pkg::OP_LIST,   32'hDEAD_BEEF, 1'b1, sle_pkg::ST_EMPTY,     5'd0},
    '{sle_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, sle_pkg::ST_NOT_FOUND, 5'd0},
    '{sle_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, sle_pkg::ST_INSERTED,  5'd1},
    '{sle_pkg::OP_INSERT, 32'h8000_0000, 1'b1, sle_pkg::ST_INSERTED,  5'd2},
    '{sle_pkg::OP_INSERT, 32'h0000_0000, 1'b1, sle_pkg::ST_INSERTED,  5'd3},
    '{sle_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, sle_pkg::ST_INSERTED,  5'd4},
    '{sle_pkg::OP_INSERT, 32'h0000_0001, 1'b1, sle_pkg::ST_INSERTED,  5'd5},
    '{sle_pkg::OP_INSERT, 32'h0000_0000, 1'b1, sle_pkg::ST_INSERTED,  5'd6},
    '{sle_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, sle_pkg::ST_INSERTED,  5'd7},
    '{sle_pkg::OP_INSERT, 32'h8000_0000, 1'b1, sle_pkg::ST_INSERTED,  5'd8},
    '{sle_pkg::OP_INSERT, 32'h5555_5555, 1'b1, sle_pkg::ST_INSERTED,  5'd9},
    '{sle_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b1, sle_pkg::ST_INSERTED,  5'd10},
    '{sle_pkg::OP_INSERT, 32'h0000_FFFF, 1'b1, sle_pkg::ST_INSERTED,  5'd11},
    '{sle_pkg::OP_INSERT, 32'hFFFF_0000, 1'b1, sle_pkg::ST_INSERTED,  5'd12},
    '{sle_pkg::OP_INSERT, 32'h1234_5678, 1'b1, sle_pkg::ST_INSERTED,  5'd13},
    '{sle_pkg::OP_INSERT, 32'h8765_4321, 1'b1, sle_pkg::ST_INSERTED,  5'd14},
    '{sle_pkg::OP_INSERT, 32'hFFFF_FFFE, 1'b1, sle_pkg::ST_INSERTED,  5'd15},
    '{sle_pkg::OP_INSERT, 32'h0000_0002, 1'b1, sle_pkg::ST_INSERTED,  5'd16},
    '{sle_pkg::OP_INSERT, 32'h0000_0003, 1'b1, sle_pkg::ST_FULL,      5'd16},
    '{sle_pkg::OP_LIST,   32'h0000_0000, 1'b0, sle_pkg::ST_LISTED,    5'd0},
    '{sle_pkg::OP_DELETE, 32'h7FFF_FFFF, 1'b0, sle_pkg::ST_DELETED,   5'd0},
    '{sle_pkg::OP_SEARCH, 32'h8000_0000, 1'b0, sle_pkg::ST_FOUND,     5'd0}
  };

  sorted_list_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow list and collect the results it causes.
  function automatic void apply_request(input logic [sle_pkg::OPCODE_W-1:0] op,
                                        input logic [sle_pkg::FIELD_W-1:0] raw,
                                        ref result_t outq [$]);
    logic signed [sle_pkg::FIELD_W-1:0] v;
    int i;
    int j;
    logic hit;
    v = raw;
    case (op)
      sle_pkg::OP_INSERT: begin
        if (shadow_count >= LIST_DEPTH) begin
          outq.push_back('{sle_pkg::ST_FULL, raw, sle_pkg::COUNT_W'(shadow_count), 1'b1});
        end else begin
          i = 0;
          while (i < shadow_count && shadow_list[i] < v) i++;
          for (j = shadow_count; j > i; j--) shadow_list[j] = shadow_list[j-1];
          shadow_list[i] = v;
          shadow_count++;
          outq.push_back('{sle_pkg::ST_INSERTED, raw, sle_pkg::COUNT_W'(shadow_count),
                           1'b1});
        end
      end
      sle_pkg::OP_SEARCH: begin
        hit = 1'b0;
        for (i = 0; i < shadow_count; i++) if (shadow_list[i] == v) hit = 1'b1;
        outq.push_back('{hit ? sle_pkg::ST_FOUND : sle_pkg::ST_NOT_FOUND, raw,
                         sle_pkg::COUNT_W'(shadow_count), 1'b1});
      end
      sle_pkg::OP_DELETE: begin
        i = 0;
        while (i < shadow_count && shadow_list[i] != v) i++;
        if (i >= shadow_count) begin
          outq.push_back('{sle_pkg::ST_NOT_FOUND, raw, sle_pkg::COUNT_W'(shadow_count),
                           1'b1});
        end else begin
          for (j = i; j + 1 < shadow_count; j++) shadow_list[j] = shadow_list[j+1];
          shadow_count--;
          outq.push_back('{sle_pkg::ST_DELETED, raw, sle_pkg::COUNT_W'(shadow_count),
                           1'b1});
        end
      end
      default: begin
        if (shadow_count == 0) begin
          outq.push_back('{sle_pkg::ST_EMPTY, raw, sle_pkg::COUNT_W'(0), 1'b1});
        end else begin
          for (i = 0; i < shadow_count; i++)
            outq.push_back('{sle_pkg::ST_LISTED, shadow_list[i],
                             sle_pkg::COUNT_W'(shadow_count), (i + 1 == shadow_count)});
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what,
             got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : scoreboard
    result_t fresh [$];
    result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_sorted_list_engine: done, errors");
      $finish;
    end
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_tdata, '0);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (m_tuser !== want.status)
            report_mismatch("status", 40'(m_tuser), 40'(want.status));
          if (m_tdata[31:0] !== want.value)
            report_mismatch("element_value", 40'(m_tdata[31:0]), 40'(want.value));
          if (m_tdata[36:32] !== want.count)
            report_mismatch("entry_count", 40'(m_tdata[36:32]), 40'(want.count));
          if (m_tlast !== want.last)
            report_mismatch("last", 40'(m_tlast), 40'(want.last));
        end
      end
      if (s_tvalid && s_tready) begin
        fresh.delete();
        apply_request(s_tuser, s_tdata, fresh);
        if (row_typed.valid) fresh = '{row_typed.res};
        foreach (fresh[k]) begin
          if (fresh[k].status == sle_pkg::ST_FULL) full_answers++;
          if (fresh[k].status == sle_pkg::ST_EMPTY) empty_answers++;
          expected_results.push_back(fresh[k]);
        end
      end
    end
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_request(input logic [sle_pkg::OPCODE_W-1:0] op,
                              input logic [sle_pkg::FIELD_W-1:0] operand,
                              input typed_result_t typed);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid  = 1'b1;
    s_tuser   = op;
    s_tdata   = operand;
    row_typed = typed;
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    @(negedge clk);
  endtask

  function automatic logic [sle_pkg::OPCODE_W-1:0] pick_opcode(input logic draining);
    int r;
    r = $urandom_range(99);
    if (r < 10) return sle_pkg::OP_LIST;
    if (r < 25) return sle_pkg::OP_SEARCH;
    if (r < 45) return draining ? sle_pkg::OP_INSERT : sle_pkg::OP_DELETE;
    return draining ? sle_pkg::OP_DELETE : sle_pkg::OP_INSERT;
  endfunction

  // Bias toward values that are held or sit at the extremes so hits occur.
  function automatic logic [sle_pkg::FIELD_W-1:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: begin
        if (shadow_count > 0) return shadow_list[$urandom_range(shadow_count - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_for_results();
    s_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    typed_result_t typed;
    int n;
    int phase;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    src_idle_pct   = 17;
    sink_stall_pct = 58;
    for (n = 0; n < NUM_ROWS; n++) begin
      typed.valid = directed_rows[n].typed;
      typed.res   = '{directed_rows[n].status, directed_rows[n].operand,
                      directed_rows[n].count, 1'b1};
      send_request(directed_rows[n].op, directed_rows[n].operand, typed);
    end
    wait_for_results();

    typed = '0;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 17; sink_stall_pct = 58; end
        1: begin src_idle_pct = 58; sink_stall_pct = 17; end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        logic draining;
        logic [sle_pkg::OPCODE_W-1:0] op;
        draining = (((phase * PHASE_ITEMS + n) / 25) % 2) == 1;
        op = pick_opcode(draining);
        send_request(op, pick_operand(), typed);
      end
      // hold the source until the engine has drained
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d requests and %0d results checked", requests_sent,
             results_checked);
    $display("full rejections: %0d, empty-list answers: %0d", full_answers,
             empty_answers);
    if (error_count == 0) begin
      $display("tb_sorted_list_engine: done, clean");
    end else begin
      $display("tb_sorted_list_engine: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/sle_pkg.sv
sv/sle_ctrl.sv
sv/sle_dpath.sv
sv/sorted_list_engine.sv
sv/sle_checker.sv
tb/tb_sorted_list_engine.sv
